/* src/odq_pkg.sv */
// odq_pkg: shared types, constants and helpers of the ordered deque
// no dependencies; used by the interfaces, the cell and the top level
package odq_pkg;

  // storage geometry
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // beat field widths
  localparam int REQ_W    = 3;
  localparam int ITEM_W   = 32;
  localparam int STATUS_W = 2;
  localparam int ENTRY_W  = 5;

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [IDX_W-1:0]      idx_t;

  // request codes on the input channel
  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_DELETE     = 3'd4
  } req_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // command broadcast to every cell
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_SHIFT_IN_FRONT,
    CMD_LOAD_TAIL,
    CMD_SHIFT_OUT_FRONT,
    CMD_DELETE
  } cmd_t;

  typedef struct packed {
    cmd_t  cmd;
    data_t value;
    cnt_t  count;
  } cell_ctl_t;

  // sign-extend or truncate a stored value to the result width
  function automatic logic signed [ITEM_W-1:0] widen(input data_t v);
    logic signed [DATA_WIDTH-1:0] s;
    s = $signed(v);
    return ITEM_W'(s);
  endfunction

endpackage

/* src/odq_if.sv */
// odq_in_if / odq_out_if: valid-ready channels of the ordered deque
// depends on odq_pkg for the field widths
interface odq_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [odq_pkg::REQ_W-1:0]            req_type;
  logic signed [odq_pkg::ITEM_W-1:0]    item_value;

  modport source (output valid, req_type, item_value, input ready);
  modport sink   (input valid, req_type, item_value, output ready);
endinterface

interface odq_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [odq_pkg::ITEM_W-1:0]    removed_value;
  logic [odq_pkg::STATUS_W-1:0]         status;
  logic [odq_pkg::ENTRY_W-1:0]          entry_count;

  modport source (output valid, removed_value, status, entry_count, input ready);
  modport sink   (input valid, removed_value, status, entry_count, output ready);
endinterface

/* src/ordered_deque_with_delete_top.sv */
// ordered_deque_with_delete_top: bounded ordered deque with delete-first-match
// depends on odq_pkg, odq_if (channels) and odq_cell (row of entry cells)
//
//  channel   | dir | beat payload                              | handshake
//  ----------+-----+-------------------------------------------+-------------
//  in_bus    | in  | req_type, item_value                      | valid/ready
//  out_bus   | out | removed_value, status, entry_count        | valid/ready
//
// to serve a request the cells compare and shift in parallel,
// and the first-match flag ripples once along the row of DEPTH cells.
// a result sits in the output register, valid the cycle after its request beat;
// in_bus.ready is high while that register is empty or being drained, so one
// request per cycle flows when out_bus.ready is high.
// synchronous active-low reset clears the entry count and output valid and holds
// in_bus.ready low; entries are not cleared, only slots below the count are read.
module ordered_deque_with_delete_top (
  input logic       clk,
  input logic       rst_n,
  odq_in_if.sink    in_bus,
  odq_out_if.source out_bus
);

  odq_pkg::cnt_t             count_r;
  odq_pkg::cnt_t             count_nxt;
  odq_pkg::cnt_t             count_out_r;
  logic                      out_valid_r;
  logic signed [odq_pkg::ITEM_W-1:0] removed_r;
  logic signed [odq_pkg::ITEM_W-1:0] removed_nxt;
  odq_pkg::status_t          status_r;
  odq_pkg::status_t          status_nxt;
  odq_pkg::cmd_t             cmd;
  odq_pkg::cell_ctl_t        ctl;
  odq_pkg::data_t            value;
  odq_pkg::data_t            cell_data [odq_pkg::DEPTH];
  logic                      found [odq_pkg::DEPTH+1];
  logic                      accept;
  logic                      full;
  logic                      empty;
  odq_pkg::idx_t             tail_idx;

  assign accept       = in_bus.valid && in_bus.ready;
  assign in_bus.ready = rst_n && (!out_valid_r || out_bus.ready);
  assign value        = odq_pkg::DATA_WIDTH'($unsigned(in_bus.item_value));
  assign full         = (count_r == odq_pkg::CNT_W'(odq_pkg::DEPTH));
  assign empty        = (count_r == '0);
  assign tail_idx     = odq_pkg::IDX_W'(count_r - odq_pkg::CNT_W'(1));

  // decode the request into a cell command and a result
  always_comb begin
    cmd         = odq_pkg::CMD_HOLD;
    status_nxt  = odq_pkg::ST_OK;
    removed_nxt = '0;
    count_nxt   = count_r;
    case (odq_pkg::req_t'(in_bus.req_type))
      odq_pkg::REQ_PUSH_FRONT, odq_pkg::REQ_PUSH_BACK: begin
        if (full) begin
          status_nxt = odq_pkg::ST_FULL;
        end else begin
          cmd = (in_bus.req_type == odq_pkg::REQ_PUSH_FRONT) ?
                odq_pkg::CMD_SHIFT_IN_FRONT : odq_pkg::CMD_LOAD_TAIL;
          count_nxt = count_r + odq_pkg::CNT_W'(1);
        end
      end
      odq_pkg::REQ_POP_FRONT: begin
        if (empty) begin
          status_nxt  = odq_pkg::ST_EMPTY;
          removed_nxt = '1;
        end else begin
          cmd         = odq_pkg::CMD_SHIFT_OUT_FRONT;
          removed_nxt = odq_pkg::widen(cell_data[0]);
          count_nxt   = count_r - odq_pkg::CNT_W'(1);
        end
      end
      odq_pkg::REQ_POP_BACK: begin
        if (empty) begin
          status_nxt  = odq_pkg::ST_EMPTY;
          removed_nxt = '1;
        end else begin
          removed_nxt = odq_pkg::widen(cell_data[tail_idx]);
          count_nxt   = count_r - odq_pkg::CNT_W'(1);
        end
      end
      odq_pkg::REQ_DELETE: begin
        if (found[odq_pkg::DEPTH]) begin
          cmd         = odq_pkg::CMD_DELETE;
          removed_nxt = odq_pkg::widen(value);
          count_nxt   = count_r - odq_pkg::CNT_W'(1);
        end else begin
          status_nxt = odq_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        cmd = odq_pkg::CMD_HOLD;
      end
    endcase
  end

  // broadcast to the row, only on an accepted beat
  always_comb begin
    ctl.cmd   = accept ? cmd : odq_pkg::CMD_HOLD;
    ctl.value = value;
    ctl.count = count_r;
  end

  // row of entry cells, first-match flag chained front to back
  assign found[0] = 1'b0;
  for (genvar i = 0; i < odq_pkg::DEPTH; i++) begin : g_cell
    odq_pkg::data_t left_d;
    odq_pkg::data_t right_d;
    assign left_d  = (i == 0) ? cell_data[i] : cell_data[(i == 0) ? 0 : i - 1];
    assign right_d = (i == odq_pkg::DEPTH - 1) ? cell_data[i] :
                     cell_data[(i == odq_pkg::DEPTH - 1) ? i : i + 1];
    odq_cell u_cell (
      .clk        (clk),
      .idx        (odq_pkg::IDX_W'(i)),
      .ctl        (ctl),
      .left_data  (left_d),
      .right_data (right_d),
      .found_in   (found[i]),
      .data       (cell_data[i]),
      .found_out  (found[i+1])
    );
  end

  // entry count and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload register
  always_ff @(posedge clk) begin
    if (accept) begin
      removed_r <= removed_nxt;
      status_r  <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) count_out_r <= count_nxt;
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.removed_value = removed_r;
  assign out_bus.status        = status_r;
  assign out_bus.entry_count   = odq_pkg::ENTRY_W'(count_out_r);

endmodule

/* src/odq_cell.sv */
// odq_cell: one entry of the shifting row, with its own compare
// depends on odq_pkg; instantiated once per entry by the top level
module odq_cell (
  input  logic               clk,
  input  logic [odq_pkg::IDX_W-1:0] idx,
  input  odq_pkg::cell_ctl_t ctl,
  input  odq_pkg::data_t     left_data,
  input  odq_pkg::data_t     right_data,
  input  logic               found_in,
  output odq_pkg::data_t     data,
  output logic               found_out
);

  odq_pkg::data_t data_r;
  odq_pkg::data_t data_nxt;
  logic           occupied;
  logic           hit;
  logic           is_head;
  logic           is_tail_slot;

  assign occupied     = odq_pkg::CNT_W'(idx) < ctl.count;
  assign hit          = occupied && (data_r == ctl.value);
  assign found_out    = found_in || hit;
  assign is_head      = (idx == '0);
  assign is_tail_slot = (odq_pkg::CNT_W'(idx) == ctl.count);

  // next entry value
  always_comb begin
    data_nxt = data_r;
    case (ctl.cmd)
      odq_pkg::CMD_SHIFT_IN_FRONT: data_nxt = is_head ? ctl.value : left_data;
      odq_pkg::CMD_LOAD_TAIL: begin
        if (is_tail_slot) data_nxt = ctl.value;
      end
      odq_pkg::CMD_SHIFT_OUT_FRONT: data_nxt = right_data;
      odq_pkg::CMD_DELETE: begin
        // close the gap from the first match onward
        if (found_out) data_nxt = right_data;
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule
